// ----- rtl/cps_pkg.sv -----
// shared types, widths and status codes for the closest point on segment block
package cps_pkg;

    localparam int COORD_W   = 32;
    localparam int DIFF_W    = COORD_W + 1;
    localparam int PROD_W    = 2 * COORD_W + 2;
    localparam int DOT_W     = PROD_W + 1;
    localparam int LEN_W     = COORD_W + 1;
    localparam int LEN_STEPS = LEN_W;
    localparam int AXES      = 3;

    localparam logic [1:0] ST_INTERIOR = 2'd0;
    localparam logic [1:0] ST_START    = 2'd1;
    localparam logic [1:0] ST_END      = 2'd2;
    localparam logic [1:0] ST_ZERO     = 2'd3;

    typedef logic signed [COORD_W-1:0] t_coord;
    typedef logic signed [DIFF_W-1:0]  t_diff;

    typedef struct packed {
        logic                 mode;
        t_coord               point_x;
        t_coord               point_y;
        t_coord               point_z;
        t_coord               start_x;
        t_coord               start_y;
        t_coord               start_z;
        t_coord               end_x;
        t_coord               end_y;
        t_coord               end_z;
        logic [COORD_W-2:0]   given_length;
    } t_in_item;

    typedef struct packed {
        t_coord       near_x;
        t_coord       near_y;
        t_coord       near_z;
        logic [1:0]   clamp_status;
    } t_out_item;

    // carried alongside the square root stages
    typedef struct packed {
        t_coord [AXES-1:0]        a;
        t_diff  [AXES-1:0]        ba;
        logic                     mode;
        logic [COORD_W-2:0]       glen;
        logic signed [DOT_W-1:0]  dot;
    } t_sqrt_sb;

    // carried alongside the divider stages
    typedef struct packed {
        t_coord [AXES-1:0]   a;
        t_diff  [AXES-1:0]   ba;
        logic [1:0]          status;
        logic [LEN_W-1:0]    d;
    } t_div_sb;

endpackage

// ----- rtl/cps_in_if.sv -----
// query channel: valid, ready and one query item
interface cps_in_if;
    logic                valid;
    logic                ready;
    cps_pkg::t_in_item   data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ----- rtl/cps_out_if.sv -----
// result channel: valid, ready and one nearest point item
interface cps_out_if;
    logic                valid;
    logic                ready;
    cps_pkg::t_out_item  data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ----- rtl/closest_point_on_segment_core.sv -----
// top level: nearest point on a 3d segment, fully pipelined
//
// i_in carries one query (point, segment start and end, mode, given length);
// o_out carries the nearest point and a clamp status. both are valid/ready
// channels, a transfer happens when valid and ready are high at a clock edge.
// mode 0 takes the segment length as the floor square root of |end-start|^2,
// mode 1 takes given_length. a zero length returns start with status 3.
// from input transfer to output valid the pipeline has three entry
// stages (differences, products, sums), 33 square root stages, three length
// and clamp stages, 33 stages for the projection divide, one scaling stage,
// 33 stages for the three per-axis divides, and the output register.
// throughput is one query per cycle while o_out is not stalled; the divider
// and square root chains resolve one bit per stage and set the depth.
// when the receiver holds o_out.ready low with a result waiting, the whole
// pipeline freezes and i_in.ready drops; nothing is lost or repeated.
// a synchronous active-low reset clears all valid bits; data is not reset.
module closest_point_on_segment_core (
    input  logic  i_clk,
    input  logic  i_rst_n,
    cps_in_if.sink    i_in,
    cps_out_if.source o_out
);
    import cps_pkg::*;

    logic w_en;

    // entry stages
    logic                    r_v1, r_v2, r_v3;
    t_coord [AXES-1:0]       r1_a, r2_a, r3_a;
    t_diff  [AXES-1:0]       r1_ba, r2_ba, r3_ba;
    t_diff  [AXES-1:0]       r1_c;
    logic                    r1_mode, r2_mode, r3_mode;
    logic [COORD_W-2:0]      r1_glen, r2_glen, r3_glen;
    logic signed [PROD_W-1:0] r2_pd [AXES];
    logic [PROD_W-1:0]       r2_ps [AXES];
    logic signed [DOT_W-1:0] r3_dot;
    logic [PROD_W-1:0]       r3_sq;

    // square root section
    logic [LEN_STEPS-1:0]    r_vsq;
    t_sqrt_sb                r_sqsb [LEN_STEPS];
    logic [LEN_W-1:0]        w_root;
    t_sqrt_sb                w_sqsb_in;

    // length and clamp stages
    logic                    r_v4, r_v5, r_v6;
    logic [LEN_W-1:0]        r4_d, r5_d, r6_d;
    logic                    r4_neg, r5_neg;
    logic [PROD_W-1:0]       r4_mag, r5_mag, r6_num;
    logic [PROD_W-1:0]       r5_dd;
    t_coord [AXES-1:0]       r4_a, r5_a, r6_a;
    t_diff  [AXES-1:0]       r4_ba, r5_ba, r6_ba;
    logic [1:0]              r6_status;
    logic [LEN_W-1:0]        w_d;
    logic signed [DOT_W-1:0] w_negdot;
    logic [1:0]              w_status;

    // projection divide
    logic [LEN_STEPS-1:0]    r_vdt;
    t_div_sb                 r_dtsb [LEN_STEPS];
    t_div_sb                 w_dtsb_in;
    logic [LEN_W-1:0]        w_t;

    // scaling stage and per-axis divides
    logic                    r_v7;
    t_div_sb                 r7_sb;
    logic [PROD_W-1:0]       r7_prod [AXES];
    logic [PROD_W-1:0]       w_prod [AXES];
    logic [LEN_STEPS-1:0]    r_vln;
    t_div_sb                 r_lnsb [LEN_STEPS];
    logic [LEN_W-1:0]        w_quo [AXES];

    // output register
    logic                    r_v8;
    t_out_item               r8_out;
    t_out_item               n_out;

    assign w_en        = !r_v8 || o_out.ready;
    assign i_in.ready  = w_en;
    assign o_out.valid = r_v8;
    assign o_out.data  = r8_out;

    // valid chain
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1  <= 1'b0;
            r_v2  <= 1'b0;
            r_v3  <= 1'b0;
            r_vsq <= '0;
            r_v4  <= 1'b0;
            r_v5  <= 1'b0;
            r_v6  <= 1'b0;
            r_vdt <= '0;
            r_v7  <= 1'b0;
            r_vln <= '0;
            r_v8  <= 1'b0;
        end else if (w_en) begin
            r_v1  <= i_in.valid;
            r_v2  <= r_v1;
            r_v3  <= r_v2;
            r_vsq <= {r_vsq[LEN_STEPS-2:0], r_v3};
            r_v4  <= r_vsq[LEN_STEPS-1];
            r_v5  <= r_v4;
            r_v6  <= r_v5;
            r_vdt <= {r_vdt[LEN_STEPS-2:0], r_v6};
            r_v7  <= r_vdt[LEN_STEPS-1];
            r_vln <= {r_vln[LEN_STEPS-2:0], r_v7};
            r_v8  <= r_vln[LEN_STEPS-1];
        end
    end

    // stages 1 to 3: differences, products, sums
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r1_a[0]  <= i_in.data.start_x;
            r1_a[1]  <= i_in.data.start_y;
            r1_a[2]  <= i_in.data.start_z;
            r1_ba[0] <= DIFF_W'(i_in.data.end_x) - DIFF_W'(i_in.data.start_x);
            r1_ba[1] <= DIFF_W'(i_in.data.end_y) - DIFF_W'(i_in.data.start_y);
            r1_ba[2] <= DIFF_W'(i_in.data.end_z) - DIFF_W'(i_in.data.start_z);
            r1_c[0]  <= DIFF_W'(i_in.data.point_x) - DIFF_W'(i_in.data.start_x);
            r1_c[1]  <= DIFF_W'(i_in.data.point_y) - DIFF_W'(i_in.data.start_y);
            r1_c[2]  <= DIFF_W'(i_in.data.point_z) - DIFF_W'(i_in.data.start_z);
            r1_mode  <= i_in.data.mode;
            r1_glen  <= i_in.data.given_length;

            for (int i = 0; i < AXES; i++) begin
                r2_pd[i] <= PROD_W'($signed(r1_ba[i])) * PROD_W'($signed(r1_c[i]));
                r2_ps[i] <= PROD_W'($signed(r1_ba[i])) * PROD_W'($signed(r1_ba[i]));
            end
            r2_a    <= r1_a;
            r2_ba   <= r1_ba;
            r2_mode <= r1_mode;
            r2_glen <= r1_glen;

            r3_dot  <= DOT_W'(r2_pd[0]) + DOT_W'(r2_pd[1]) + DOT_W'(r2_pd[2]);
            r3_sq   <= r2_ps[0] + r2_ps[1] + r2_ps[2];
            r3_a    <= r2_a;
            r3_ba   <= r2_ba;
            r3_mode <= r2_mode;
            r3_glen <= r2_glen;
        end
    end

    cps_sqrt u_sqrt (
        .i_clk      (i_clk),
        .i_en       (w_en),
        .i_radicand (r3_sq),
        .o_root     (w_root)
    );

    always_comb begin
        w_sqsb_in.a    = r3_a;
        w_sqsb_in.ba   = r3_ba;
        w_sqsb_in.mode = r3_mode;
        w_sqsb_in.glen = r3_glen;
        w_sqsb_in.dot  = r3_dot;
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_sqsb[0] <= w_sqsb_in;
            for (int k = 1; k < LEN_STEPS; k++) begin
                r_sqsb[k] <= r_sqsb[k-1];
            end
        end
    end

    // stages 4 to 6: length select, d*(d+1), clamp decision
    assign w_d      = r_sqsb[LEN_STEPS-1].mode ? LEN_W'(r_sqsb[LEN_STEPS-1].glen) : w_root;
    assign w_negdot = -r_sqsb[LEN_STEPS-1].dot;

    always_comb begin
        if (r5_d == '0) begin
            w_status = ST_ZERO;
        end else if (r5_neg && (r5_mag >= PROD_W'(r5_d))) begin
            w_status = ST_START;
        end else if (!r5_neg && (r5_mag >= r5_dd)) begin
            // quotient would exceed the length
            w_status = ST_END;
        end else begin
            w_status = ST_INTERIOR;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r4_d   <= w_d;
            r4_neg <= r_sqsb[LEN_STEPS-1].dot[DOT_W-1];
            r4_mag <= r_sqsb[LEN_STEPS-1].dot[DOT_W-1] ? w_negdot[PROD_W-1:0]
                                                       : r_sqsb[LEN_STEPS-1].dot[PROD_W-1:0];
            r4_a   <= r_sqsb[LEN_STEPS-1].a;
            r4_ba  <= r_sqsb[LEN_STEPS-1].ba;

            r5_dd  <= PROD_W'(r4_d) * PROD_W'(r4_d) + PROD_W'(r4_d);
            r5_d   <= r4_d;
            r5_neg <= r4_neg;
            r5_mag <= r4_mag;
            r5_a   <= r4_a;
            r5_ba  <= r4_ba;

            r6_status <= w_status;
            r6_num    <= r5_neg ? '0 : r5_mag;
            r6_d      <= r5_d;
            r6_a      <= r5_a;
            r6_ba     <= r5_ba;
        end
    end

    cps_div u_div_t (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_num (r6_num),
        .i_den (r6_d),
        .o_quo (w_t)
    );

    always_comb begin
        w_dtsb_in.a      = r6_a;
        w_dtsb_in.ba     = r6_ba;
        w_dtsb_in.status = r6_status;
        w_dtsb_in.d      = r6_d;
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_dtsb[0] <= w_dtsb_in;
            for (int k = 1; k < LEN_STEPS; k++) begin
                r_dtsb[k] <= r_dtsb[k-1];
            end
        end
    end

    // stage 7: |ba| * t per axis
    always_comb begin
        for (int i = 0; i < AXES; i++) begin
            w_prod[i] = r_dtsb[LEN_STEPS-1].ba[i][DIFF_W-1]
                      ? PROD_W'(-r_dtsb[LEN_STEPS-1].ba[i]) * PROD_W'(w_t)
                      : PROD_W'(r_dtsb[LEN_STEPS-1].ba[i]) * PROD_W'(w_t);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int i = 0; i < AXES; i++) begin
                r7_prod[i] <= w_prod[i];
            end
            r7_sb <= r_dtsb[LEN_STEPS-1];
        end
    end

    genvar g;
    generate
        for (g = 0; g < AXES; g++) begin : g_lane
            cps_div u_div_ln (
                .i_clk (i_clk),
                .i_en  (w_en),
                .i_num (r7_prod[g]),
                .i_den (r7_sb.d),
                .o_quo (w_quo[g])
            );
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_lnsb[0] <= r7_sb;
            for (int k = 1; k < LEN_STEPS; k++) begin
                r_lnsb[k] <= r_lnsb[k-1];
            end
        end
    end

    // stage 8: final point
    always_comb begin
        t_coord [AXES-1:0] near;
        t_coord            a_i;
        t_coord            step;
        t_div_sb           sb;
        sb = r_lnsb[LEN_STEPS-1];
        for (int i = 0; i < AXES; i++) begin
            a_i  = sb.a[i];
            step = COORD_W'(w_quo[i]);
            case (sb.status)
                ST_ZERO, ST_START: near[i] = a_i;
                ST_END:            near[i] = a_i + COORD_W'(sb.ba[i]);
                ST_INTERIOR:       near[i] = sb.ba[i][DIFF_W-1] ? a_i - step : a_i + step;
                default:           near[i] = a_i;
            endcase
        end
        n_out.near_x       = near[0];
        n_out.near_y       = near[1];
        n_out.near_z       = near[2];
        n_out.clamp_status = sb.status;
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r8_out <= n_out;
        end
    end

    // an interior projection never exceeds the length
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vdt[LEN_STEPS-1] && (r_dtsb[LEN_STEPS-1].status == ST_INTERIOR))
        |-> (w_t <= r_dtsb[LEN_STEPS-1].d))
        else $error("projection above segment length on interior item");

    // per-axis steps fit a coordinate
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vln[LEN_STEPS-1] && (r_lnsb[LEN_STEPS-1].status == ST_INTERIOR))
        |-> (!w_quo[0][LEN_W-1] && !w_quo[1][LEN_W-1] && !w_quo[2][LEN_W-1]))
        else $error("axis step overflow");

    assert property (@(posedge i_clk)
        !i_rst_n |=> (!r_v1 && r_vsq == '0 && r_vdt == '0 && r_vln == '0 && !r_v8))
        else $error("pipeline not empty after reset");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_en |=> ($stable(r_vsq) && $stable(r_vdt) && $stable(r_vln)))
        else $error("pipeline moved while stalled");

endmodule

// ----- rtl/cps_sqrt.sv -----
// pipelined floor square root, one root bit per stage
module cps_sqrt (
    input  logic                         i_clk,
    input  logic                         i_en,
    input  logic [cps_pkg::PROD_W-1:0]   i_radicand,
    output logic [cps_pkg::LEN_W-1:0]    o_root
);
    import cps_pkg::*;

    logic [PROD_W-1:0] r_rem  [LEN_STEPS];
    logic [LEN_W-1:0]  r_root [LEN_STEPS];

    genvar k;
    generate
        for (k = 0; k < LEN_STEPS; k++) begin : g_stage
            localparam int BIT = LEN_STEPS - 1 - k;
            logic [PROD_W-1:0] rem_in;
            logic [PROD_W-1:0] trial;
            logic [PROD_W-1:0] n_rem;
            logic [LEN_W-1:0]  root_in;
            logic [LEN_W-1:0]  n_root;

            if (k == 0) begin : g_first
                assign rem_in  = i_radicand;
                assign root_in = '0;
            end else begin : g_next
                assign rem_in  = r_rem[k-1];
                assign root_in = r_root[k-1];
            end

            // (r + 2^i)^2 - r^2
            assign trial = (PROD_W'(root_in) << (BIT + 1)) | (PROD_W'(1) << (2 * BIT));

            always_comb begin
                n_rem  = rem_in;
                n_root = root_in;
                if (rem_in >= trial) begin
                    n_rem  = rem_in - trial;
                    n_root = root_in | (LEN_W'(1) << BIT);
                end
            end

            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem[k]  <= n_rem;
                    r_root[k] <= n_root;
                end
            end
        end
    endgenerate

    assign o_root = r_root[LEN_STEPS-1];

endmodule

// ----- rtl/cps_div.sv -----
// pipelined restoring divider, one quotient bit per stage
module cps_div (
    input  logic                         i_clk,
    input  logic                         i_en,
    input  logic [cps_pkg::PROD_W-1:0]   i_num,
    input  logic [cps_pkg::LEN_W-1:0]    i_den,
    output logic [cps_pkg::LEN_W-1:0]    o_quo
);
    import cps_pkg::*;

    logic [PROD_W-1:0] r_rem [LEN_STEPS];
    logic [LEN_W-1:0]  r_den [LEN_STEPS];
    logic [LEN_W-1:0]  r_quo [LEN_STEPS];

    genvar k;
    generate
        for (k = 0; k < LEN_STEPS; k++) begin : g_stage
            localparam int BIT = LEN_STEPS - 1 - k;
            logic [PROD_W-1:0] rem_in;
            logic [PROD_W-1:0] trial;
            logic [PROD_W-1:0] n_rem;
            logic [LEN_W-1:0]  den_in;
            logic [LEN_W-1:0]  quo_in;
            logic [LEN_W-1:0]  n_quo;

            if (k == 0) begin : g_first
                assign rem_in = i_num;
                assign den_in = i_den;
                assign quo_in = '0;
            end else begin : g_next
                assign rem_in = r_rem[k-1];
                assign den_in = r_den[k-1];
                assign quo_in = r_quo[k-1];
            end

            assign trial = PROD_W'(den_in) << BIT;

            always_comb begin
                n_rem = rem_in;
                n_quo = quo_in;
                if (rem_in >= trial) begin
                    n_rem = rem_in - trial;
                    n_quo = quo_in | (LEN_W'(1) << BIT);
                end
            end

            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem[k] <= n_rem;
                    r_den[k] <= den_in;
                    r_quo[k] <= n_quo;
                end
            end
        end
    endgenerate

    assign o_quo = r_quo[LEN_STEPS-1];

endmodule

// ----- tb/tb_closest_point_on_segment_core.sv -----
// testbench for the closest point on segment core: directed and random queries
module tb_closest_point_on_segment_core;
    import cps_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int LATENCY = 107;

    logic i_clk;
    logic i_rst_n;

    cps_in_if  q_ch ();
    cps_out_if r_ch ();

    closest_point_on_segment_core dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (q_ch.sink),
        .o_out   (r_ch.source)
    );

    t_out_item expected_points[$];
    int        mismatches;
    bit        hold_results;
    int        long_gap_odds;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // floor square root of a nonnegative wide value
    // trial root stays below 2^34 so its square fits 68 bits
    function automatic logic [67:0] floor_sqrt(logic [67:0] v);
        logic [67:0] r;
        logic [67:0] c;
        r = '0;
        for (int i = 33; i >= 0; i--) begin
            c = r | (68'd1 << i);
            if (c * c <= v) r = c;
        end
        return r;
    endfunction

    function automatic t_out_item nearest_point(t_in_item q);
        t_out_item         res;
        logic signed [33:0] a [3];
        logic signed [33:0] b [3];
        logic signed [33:0] ba [3];
        logic signed [33:0] c [3];
        logic signed [69:0] dot;
        logic [69:0]        sq;
        logic [69:0]        len;
        logic [69:0]        t;
        logic [69:0]        step;
        logic [69:0]        mag;
        logic signed [69:0] r;
        a[0] = q.start_x; a[1] = q.start_y; a[2] = q.start_z;
        b[0] = q.end_x;   b[1] = q.end_y;   b[2] = q.end_z;
        c[0] = 34'(q.point_x) - a[0];
        c[1] = 34'(q.point_y) - a[1];
        c[2] = 34'(q.point_z) - a[2];
        dot = 0;
        sq  = 0;
        for (int i = 0; i < 3; i++) begin
            ba[i] = b[i] - a[i];
            dot += 70'(ba[i]) * 70'(c[i]);
            sq  += 70'(ba[i]) * 70'(ba[i]);
        end
        len = q.mode ? 70'(q.given_length) : 70'(floor_sqrt(68'(sq)));
        res.near_x = q.start_x;
        res.near_y = q.start_y;
        res.near_z = q.start_z;
        if (len == 0) begin
            res.clamp_status = ST_ZERO;
            return res;
        end
        if (dot < 0) begin
            if (70'(-dot) / len != 0) begin
                res.clamp_status = ST_START;
                return res;
            end
            t = 0;
        end else begin
            t = 70'(dot) / len;
            if (t > len) begin
                res.near_x = q.end_x;
                res.near_y = q.end_y;
                res.near_z = q.end_z;
                res.clamp_status = ST_END;
                return res;
            end
        end
        for (int i = 0; i < 3; i++) begin
            mag  = ba[i] < 0 ? 70'(-ba[i]) : 70'(ba[i]);
            step = (mag * t) / len;
            r    = ba[i] < 0 ? 70'(a[i]) - 70'(step) : 70'(a[i]) + 70'(step);
            if (i == 0) res.near_x = r[31:0];
            if (i == 1) res.near_y = r[31:0];
            if (i == 2) res.near_z = r[31:0];
        end
        res.clamp_status = ST_INTERIOR;
        return res;
    endfunction

    function automatic int gap_length();
        if ($urandom_range(0, 99) < long_gap_odds) return $urandom_range(20, 80);
        if ($urandom_range(0, 2) == 0) return $urandom_range(1, 3);
        return 0;
    endfunction

    task automatic send_query(t_in_item q);
        int gap;
        gap = gap_length();
        if (gap > 0) begin
            q_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        q_ch.valid <= 1'b1;
        q_ch.data  <= q;
        @(posedge i_clk);
        while (!q_ch.ready) @(posedge i_clk);
        expected_points.push_back(nearest_point(q));
    endtask

    task automatic go_idle();
        q_ch.valid <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic t_coord rand_coord(int kind);
        case (kind)
            0: return $urandom();
            1: return $signed($urandom_range(0, 32'h000F_FFFF)) - 32'sh0008_0000;
            2: return $urandom_range(0, 1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
            default: return $signed($urandom_range(0, 255)) - 32'sd128;
        endcase
    endfunction

    function automatic t_in_item rand_query();
        t_in_item q;
        int       kind;
        q = '0;
        kind = $urandom_range(0, 3);
        q.mode    = 1'($urandom_range(0, 1));
        q.start_x = rand_coord(kind); q.start_y = rand_coord(kind);
        q.start_z = rand_coord(kind);
        q.end_x   = rand_coord(kind); q.end_y   = rand_coord(kind);
        q.end_z   = rand_coord(kind);
        q.point_x = rand_coord($urandom_range(0, 3));
        q.point_y = rand_coord(kind); q.point_z = rand_coord(kind);
        case ($urandom_range(0, 9))
            0: begin
                q.end_x = q.start_x; q.end_y = q.start_y; q.end_z = q.start_z;
            end
            1: q.given_length = 0;
            2: q.given_length = 31'($urandom_range(1, 16));
            default: q.given_length = 31'($urandom());
        endcase
        // about half of mode 1 queries get a plausible length, the rest keep inconsistent ones as noise
        if (q.mode && $urandom_range(0, 1) == 0) begin
            q.given_length = 31'(floor_sqrt(68'((70'(34'(q.end_x) - 34'(q.start_x)) ** 2)
                + (70'(34'(q.end_y) - 34'(q.start_y)) ** 2)
                + (70'(34'(q.end_z) - 34'(q.start_z)) ** 2))));
            q.given_length = q.given_length + 31'($urandom_range(0, 2)) - 31'd1;
        end
        return q;
    endfunction

    function automatic t_in_item make_query(logic mode, t_coord p, t_coord a, t_coord b,
                                            logic [30:0] glen);
        t_in_item q;
        q.mode = mode;
        q.point_x = p; q.point_y = p; q.point_z = -p;
        q.start_x = a; q.start_y = a; q.start_z = -a;
        q.end_x   = b; q.end_y   = b; q.end_z   = -b;
        q.given_length = glen;
        return q;
    endfunction

    task automatic wait_drained();
        while (expected_points.size() != 0) @(posedge i_clk);
    endtask

    task automatic test_directed();
        t_in_item q;
        send_query(make_query(0, 32'sh0001_0000, 32'sh0, 32'sh0004_0000, 0));
        send_query(make_query(0, -32'sh0001_0000, 32'sh0, 32'sh0004_0000, 0));
        send_query(make_query(0, 32'sh0009_0000, 32'sh0, 32'sh0004_0000, 0));
        send_query(make_query(0, 32'sh5, 32'sh5, 32'sh5, 0));
        send_query(make_query(1, 32'sh1, 32'sh0, 32'sh0004_0000, 0));
        send_query(make_query(1, 32'sh1234, 32'sh0, 32'sh0004_0000, 31'h7FFF_FFFF));
        send_query(make_query(1, 32'sh1234, 32'sh0, 32'sh0004_0000, 31'd3));
        // small negative projection clamps to start
        send_query(make_query(0, -32'sh1, 32'sh0, 32'sh0010_0000, 0));
        send_query(make_query(0, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF, 0));
        send_query(make_query(0, 32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000, 0));
        send_query(make_query(0, 32'sh0, 32'sh8000_0000, 32'sh7FFF_FFFF, 0));
        send_query(make_query(1, 32'sh0, 32'sh8000_0000, 32'sh7FFF_FFFF, 31'h5555_5555));
        send_query(make_query(1, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 31'd1));
        send_query(make_query(0, -32'sh1, -32'sh1, 32'sh8000_0000, 0));
        q = make_query(0, 32'shFFFF_FFFF, 32'sh0, 32'shFFFF_FFFF, 31'h2AAA_AAAA);
        q.point_y = 32'sh7FFF_0000;
        send_query(q);
        go_idle();
    endtask

    task automatic test_random(int n);
        repeat (n) send_query(rand_query());
        go_idle();
    endtask

    // receiver holds off while the sender keeps offering, filling the pipe
    task automatic test_backpressure();
        hold_results = 1'b1;
        long_gap_odds = 0;
        fork
            begin
                repeat (400) @(posedge i_clk);
                hold_results = 1'b0;
            end
            test_random(250);
        join
        long_gap_odds = 3;
    endtask

    task automatic test_drain_pause();
        test_random(100);
        wait_drained();
        test_random(100);
    endtask

    initial begin
        i_rst_n       = 1'b0;
        q_ch.valid    = 1'b0;
        q_ch.data     = '0;
        r_ch.ready    = 1'b0;
        hold_results  = 1'b0;
        long_gap_odds = 3;
        mismatches    = 0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_backpressure();
        test_drain_pause();
        test_random(1480);
        wait_drained();
        repeat (LATENCY + 20) @(posedge i_clk);
        if (mismatches == 0 && expected_points.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    // result side: random stalls, forced hold-off while hold_results is set
    initial begin
        int stall;
        forever begin
            @(posedge i_clk);
            if (hold_results) begin
                r_ch.ready <= 1'b0;
            end else begin
                stall = gap_length();
                r_ch.ready <= (stall == 0);
            end
        end
    end

    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n && r_ch.valid && r_ch.ready) begin
            if (expected_points.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result %p", r_ch.data);
            end else begin
                want = expected_points.pop_front();
                if (r_ch.data.near_x !== want.near_x || r_ch.data.near_y !== want.near_y
                    || r_ch.data.near_z !== want.near_z
                    || r_ch.data.clamp_status !== want.clamp_status) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected %p actual %p", want, r_ch.data);
                end
            end
        end
    end

    initial begin
        #3ms;
        $display("FAIL");
        $finish;
    end

endmodule
